FILE: hw/rtl/gwtd_pkg.sv
`timescale 1ns / 1ps
package gwtd_pkg;

    localparam int MAX_FRACTION_DIGITS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF         = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_STOP  = 3'd1,
        ACT_SET_X = 3'd2,
        ACT_SET_Y = 3'd3,
        ACT_SET_Z = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LETTER,
        PH_NUMBER
    } phase_t;

    // one completed word, or an end-of-buffer marker, from tokenizer to dispatcher
    typedef struct packed {
        logic        emit;
        logic        flush;
        logic [7:0]  letter;
        logic        negative;
        logic [15:0] int_mag;
        logic        seen_point;
        logic [15:0] frac_acc;
        logic [2:0]  frac_cnt;
    } token_t;

endpackage

FILE: hw/rtl/gwtd_front.sv
`timescale 1ns / 1ps
module gwtd_front #(
    parameter int MAX_FRACTION_DIGITS = gwtd_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      text_byte,
    input  logic            last_byte,
    input  logic            in_valid,
    output logic            in_ready,
    output gwtd_pkg::token_t tok,
    output logic            tok_valid,
    input  logic            tok_ready
);
    import gwtd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  letter_reg, letter_next;
    logic        neg_reg, neg_next;
    logic [15:0] int_reg, int_next;
    logic [15:0] frac_reg, frac_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic        seen_reg, seen_next;

    phase_t      n_phase;
    logic [7:0]  n_letter;
    logic        n_neg;
    logic [15:0] n_int;
    logic [15:0] n_frac;
    logic [2:0]  n_fcnt;
    logic        n_seen;
    logic        is_sep;
    logic        sep_emit;
    logic        do_num;
    logic        accept;
    logic        close_word;
    logic [15:0] digit;

    assign in_ready = tok_ready;
    assign accept   = in_valid && tok_ready;
    assign is_sep   = (text_byte == CH_NL) || (text_byte == CH_SPACE) || (text_byte == CH_NUL);
    assign digit    = {8'h00, text_byte} - {8'h00, CH_ZERO};

    always_comb
    begin
        n_phase  = phase_reg;
        n_letter = letter_reg;
        n_neg    = neg_reg;
        n_int    = int_reg;
        n_frac   = frac_reg;
        n_fcnt   = fcnt_reg;
        n_seen   = seen_reg;
        sep_emit = 1'b0;
        do_num   = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!is_sep)
                begin
                    n_letter = text_byte;
                    n_phase  = PH_LETTER;
                end
            end
            PH_LETTER:
            begin
                if (is_sep)
                    sep_emit = 1'b1;
                else
                begin
                    n_phase = PH_NUMBER;
                    if (text_byte == CH_MINUS)
                        n_neg = 1'b1;
                    else
                        do_num = 1'b1;
                end
            end
            PH_NUMBER:
            begin
                if (is_sep)
                    sep_emit = 1'b1;
                else
                    do_num = 1'b1;
            end
            default:
            begin
                n_phase = PH_IDLE;
            end
        endcase

        if (do_num)
        begin
            if (text_byte == CH_POINT)
                n_seen = 1'b1;
            else if (!seen_reg)
                n_int = {int_reg[12:0], 3'b000} + {int_reg[14:0], 1'b0} + digit;
            else if (fcnt_reg < 3'(MAX_FRACTION_DIGITS))
            begin
                n_frac = {frac_reg[12:0], 3'b000} + {frac_reg[14:0], 1'b0} + digit;
                n_fcnt = fcnt_reg + 3'd1;
            end
        end

        // separator emits the word as held; last byte emits it after this byte
        tok.emit       = sep_emit || (last_byte && (n_phase != PH_IDLE));
        tok.flush      = last_byte;
        tok.letter     = sep_emit ? letter_reg : n_letter;
        tok.negative   = sep_emit ? neg_reg    : n_neg;
        tok.int_mag    = sep_emit ? int_reg    : n_int;
        tok.seen_point = sep_emit ? seen_reg   : n_seen;
        tok.frac_acc   = sep_emit ? frac_reg   : n_frac;
        tok.frac_cnt   = sep_emit ? fcnt_reg   : n_fcnt;

        close_word = tok.emit || last_byte;
        tok_valid  = accept && close_word;

        phase_next  = phase_reg;
        letter_next = letter_reg;
        neg_next    = neg_reg;
        int_next    = int_reg;
        frac_next   = frac_reg;
        fcnt_next   = fcnt_reg;
        seen_next   = seen_reg;
        if (accept)
        begin
            if (close_word)
            begin
                phase_next  = PH_IDLE;
                letter_next = 8'h00;
                neg_next    = 1'b0;
                int_next    = 16'h0000;
                frac_next   = 16'h0000;
                fcnt_next   = 3'd0;
                seen_next   = 1'b0;
            end
            else
            begin
                phase_next  = n_phase;
                letter_next = n_letter;
                neg_next    = n_neg;
                int_next    = n_int;
                frac_next   = n_frac;
                fcnt_next   = n_fcnt;
                seen_next   = n_seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            letter_reg <= 8'h00;
            neg_reg    <= 1'b0;
            int_reg    <= 16'h0000;
            frac_reg   <= 16'h0000;
            fcnt_reg   <= 3'd0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            letter_reg <= letter_next;
            neg_reg    <= neg_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            fcnt_reg   <= fcnt_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

FILE: hw/rtl/gwtd_queue.sv
`timescale 1ns / 1ps
module gwtd_queue #(
    parameter int QUEUE_DEPTH = gwtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gwtd_pkg::token_t push_tok,
    input  logic             push_valid,
    output logic             push_ready,
    output gwtd_pkg::token_t head_tok,
    output logic             head_valid,
    input  logic             pop
);
    import gwtd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg < CW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_tok   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (do_pop)
            rd_next = (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/gwtd_back.sv
`timescale 1ns / 1ps
module gwtd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  gwtd_pkg::token_t head_tok,
    input  logic             head_valid,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [7:0]       word_letter,
    output logic [16:0]      signed_integer,
    output logic             has_fraction,
    output logic [15:0]      fraction_numerator,
    output logic [2:0]       fraction_digits,
    output logic [2:0]       action
);
    import gwtd_pkg::*;

    logic        move_reg, move_next;
    logic        valid_reg, valid_next;
    logic [7:0]  letter_reg;
    logic [16:0] sint_reg;
    logic        hasf_reg;
    logic [15:0] fnum_reg;
    logic [2:0]  fdig_reg;
    action_t     act_reg;

    logic [16:0] sval;
    action_t     act;
    logic        move_after;
    logic        handled;

    assign pop = head_valid && (!valid_reg || res_ready);

    always_comb
    begin
        sval = head_tok.negative ? (17'd0 - {1'b0, head_tok.int_mag})
                                 : {1'b0, head_tok.int_mag};
        act        = ACT_NONE;
        move_after = move_reg;
        handled    = 1'b0;
        if (move_reg)
        begin
            if (head_tok.letter == CH_X)
            begin
                act     = ACT_SET_X;
                handled = 1'b1;
            end
            else if (head_tok.letter == CH_Y)
            begin
                act     = ACT_SET_Y;
                handled = 1'b1;
            end
            else if (head_tok.letter == CH_Z)
            begin
                act     = ACT_SET_Z;
                handled = 1'b1;
            end
            else
                move_after = 1'b0;
        end
        if (!handled && (head_tok.letter == CH_G))
        begin
            if (sval == 17'd0)
                act = ACT_STOP;
            else if (sval == 17'd1)
            begin
                act        = ACT_STOP;
                move_after = 1'b1;
            end
        end

        move_next = move_reg;
        if (pop && head_tok.emit)
            move_next = move_after;
        if (pop && head_tok.flush)
            move_next = 1'b0;

        valid_next = valid_reg;
        if (pop && head_tok.emit)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            move_reg  <= move_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_tok.emit)
        begin
            letter_reg <= head_tok.letter;
            sint_reg   <= sval;
            hasf_reg   <= head_tok.seen_point;
            fnum_reg   <= head_tok.seen_point ? head_tok.frac_acc : 16'h0000;
            fdig_reg   <= head_tok.seen_point ? head_tok.frac_cnt : 3'd0;
            act_reg    <= act;
        end
    end

    assign res_valid          = valid_reg;
    assign word_letter        = letter_reg;
    assign signed_integer     = sint_reg;
    assign has_fraction       = hasf_reg;
    assign fraction_numerator = fnum_reg;
    assign fraction_digits    = fdig_reg;
    assign action             = act_reg;

endmodule

FILE: hw/rtl/gcode_word_tokenizer_dispatcher_top.sv
`timescale 1ns / 1ps
// A word's closing byte writes its token into the queue; the dispatcher then moves it
// into the result register, and waits while an earlier result is not yet taken.
// Throughput: one text byte per cycle while the queue has room; tokenizer and dispatcher
// are parted by a small token queue; the tokenizer does one times-ten accumulate per digit.
// Reset (rst_n, async, active low): between words, accumulators clear, move mode off,
// queue empty, no result pending.
module gcode_word_tokenizer_dispatcher_top #(
    parameter int MAX_FRACTION_DIGITS = gwtd_pkg::MAX_FRACTION_DIGITS_DEF,
    parameter int QUEUE_DEPTH         = gwtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // word_letter[7:0], signed_integer[24:8], has_fraction[25],
    // fraction_numerator[41:26], fraction_digits[44:42], action[47:45]
    output logic [47:0] m_axis_tdata
);
    import gwtd_pkg::*;

    token_t      push_tok;
    token_t      head_tok;
    logic        push_valid;
    logic        push_ready;
    logic        head_valid;
    logic        pop;
    logic [7:0]  word_letter;
    logic [16:0] signed_integer;
    logic        has_fraction;
    logic [15:0] fraction_numerator;
    logic [2:0]  fraction_digits;
    logic [2:0]  action;

    gwtd_front #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .tok       (push_tok),
        .tok_valid (push_valid),
        .tok_ready (push_ready)
    );

    gwtd_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_tok   (push_tok),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_tok   (head_tok),
        .head_valid (head_valid),
        .pop        (pop)
    );

    gwtd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_tok           (head_tok),
        .head_valid         (head_valid),
        .pop                (pop),
        .res_valid          (m_axis_tvalid),
        .res_ready          (m_axis_tready),
        .word_letter        (word_letter),
        .signed_integer     (signed_integer),
        .has_fraction       (has_fraction),
        .fraction_numerator (fraction_numerator),
        .fraction_digits    (fraction_digits),
        .action             (action)
    );

    assign m_axis_tdata = {action, fraction_digits, fraction_numerator,
                           has_fraction, signed_integer, word_letter};

endmodule
